// ===== rtl/core/phoh_pkg.sv =====
package phoh_pkg;

  // Field and counter widths
  localparam int THRESH_W    = 26;
  localparam int CHIP_CNT_W  = 20;
  localparam int STAVE_CNT_W = 23;
  localparam int TOTAL_W     = 26;
  localparam int EVT_W       = 32;
  localparam int COUNT_W     = 23;

  // Threshold after reset: 0.025 % of 12*9*1024*512 pixels, rounded down
  localparam logic [THRESH_W-1:0] THRESH_RESET = 26'd14155;

  // Epoch tag kept with every histogram word; a word counts only when its tag
  // matches the current event's epoch
  localparam int EPOCH_W = 8;

  // Index fields sized for the largest geometry: 3 layers x 32 staves x 16 chips
  localparam int SIDX_MAX_W = 7;
  localparam int CIDX_MAX_W = 11;

  // Action codes on the input
  localparam logic [1:0] ACT_HIT  = 2'd0;
  localparam logic [1:0] ACT_EOE  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Layer code that only counts as an event entry
  localparam logic [1:0] LAYER_ENTRY_ONLY = 2'd3;

  typedef enum logic [1:0] {
    CMD_HIT,
    CMD_EOE,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] layer;
    logic [4:0] stave;
    logic [3:0] chip;
    logic       read_stave_total;
  } item_t;

  typedef struct packed {
    logic                   hit_accepted;
    logic                   bad_address;
    logic                   event_done;
    logic                   event_empty;
    logic                   above_threshold;
    logic [TOTAL_W-1:0]     layer0_total;
    logic [TOTAL_W-1:0]     layer1_total;
    logic [TOTAL_W-1:0]     layer2_total;
    logic [EVT_W-1:0]       events_processed;
    logic [EVT_W-1:0]       events_above;
    logic [COUNT_W-1:0]     count_value;
  } result_t;

  // Classified request passed from front to back
  typedef struct packed {
    cmd_kind_t              kind;
    logic [1:0]             layer;
    logic                   located;
    logic                   bad;
    logic                   rd_stave;
    logic [SIDX_MAX_W-1:0]  s_idx;
    logic [CIDX_MAX_W-1:0]  c_idx;
  } cmd_t;

  typedef struct packed {
    logic [EPOCH_W-1:0]     epoch;
    logic [CHIP_CNT_W-1:0]  cnt;
  } chip_word_t;

  typedef struct packed {
    logic [EPOCH_W-1:0]     epoch;
    logic [STAVE_CNT_W-1:0] cnt;
  } stave_word_t;

endpackage

// ===== rtl/core/phoh_fifo.sv =====
// Small request queue; DEPTH must be a power of two
module phoh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/phoh_front.sv =====
// Decodes the action and resolves layer/stave/chip into histogram indexes
module phoh_front #(
  parameter int unsigned STAVES_LAYER0   = 12,
  parameter int unsigned STAVES_LAYER1   = 16,
  parameter int unsigned STAVES_LAYER2   = 20,
  parameter int unsigned CHIPS_PER_STAVE = 9
) (
  input  phoh_pkg::item_t item,
  output phoh_pkg::cmd_t  cmd
);

  import phoh_pkg::*;

  logic [SIDX_MAX_W-1:0] limit;
  logic [SIDX_MAX_W-1:0] base;
  logic [SIDX_MAX_W-1:0] s_idx;
  logic [3:0]            chip_eff;
  logic                  need_chip;
  logic                  chip_ok;
  logic                  stave_ok;
  logic                  located;
  cmd_kind_t             kind;

  // Stave range and first stave slot of each layer
  always_comb begin
    unique case (item.layer)
      2'd0: begin
        limit = SIDX_MAX_W'(STAVES_LAYER0);
        base  = '0;
      end
      2'd1: begin
        limit = SIDX_MAX_W'(STAVES_LAYER1);
        base  = SIDX_MAX_W'(STAVES_LAYER0);
      end
      2'd2: begin
        limit = SIDX_MAX_W'(STAVES_LAYER2);
        base  = SIDX_MAX_W'(STAVES_LAYER0 + STAVES_LAYER1);
      end
      default: begin
        limit = '0;
        base  = '0;
      end
    endcase
  end

  // Action decode
  always_comb begin
    unique case (item.action)
      ACT_HIT:  kind = CMD_HIT;
      ACT_EOE:  kind = CMD_EOE;
      ACT_READ: kind = CMD_READ;
      default:  kind = CMD_NOP;
    endcase
  end

  // Geometry check; a stave read ignores the chip field
  assign need_chip = (kind == CMD_HIT) || !item.read_stave_total;
  assign chip_ok   = {1'b0, item.chip} < 5'(CHIPS_PER_STAVE);
  assign stave_ok  = {2'b00, item.stave} < limit;
  assign located   = (item.layer != LAYER_ENTRY_ONLY) && stave_ok && (!need_chip || chip_ok);
  assign chip_eff  = chip_ok ? item.chip : 4'd0;
  assign s_idx     = located ? base + SIDX_MAX_W'(item.stave) : '0;

  always_comb begin
    cmd          = '0;
    cmd.kind     = kind;
    cmd.layer    = item.layer;
    cmd.located  = located;
    cmd.rd_stave = item.read_stave_total;
    cmd.s_idx    = s_idx;
    cmd.c_idx    = located ? CIDX_MAX_W'(s_idx) * CIDX_MAX_W'(CHIPS_PER_STAVE)
                             + CIDX_MAX_W'(chip_eff) : '0;
    unique case (kind)
      CMD_HIT:  cmd.bad = (item.layer != LAYER_ENTRY_ONLY) && !located;
      CMD_READ: cmd.bad = !located;
      default:  cmd.bad = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/phoh_back.sv =====
// Executes classified requests: histogram read-modify-write, event bookkeeping
module phoh_back #(
  parameter int unsigned STAVES_LAYER0   = 12,
  parameter int unsigned STAVES_LAYER1   = 16,
  parameter int unsigned STAVES_LAYER2   = 20,
  parameter int unsigned CHIPS_PER_STAVE = 9
) (
  input  logic                            clk,
  input  logic                            rst,
  input  phoh_pkg::cmd_t                  cmd,
  input  logic                            cmd_empty,
  output logic                            cmd_pop,
  output phoh_pkg::result_t               res,
  output logic                            res_push,
  input  logic                            res_full,
  input  logic                            cfg_we,
  input  logic [phoh_pkg::THRESH_W-1:0]   cfg_data,
  output logic                            busy
);

  import phoh_pkg::*;

  localparam int unsigned STAVE_SLOTS = STAVES_LAYER0 + STAVES_LAYER1 + STAVES_LAYER2;
  localparam int unsigned CHIP_SLOTS  = STAVE_SLOTS * CHIPS_PER_STAVE;
  localparam int SIDX_W = $clog2(STAVE_SLOTS);
  localparam int CIDX_W = $clog2(CHIP_SLOTS);

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  state_t            state;
  logic [CIDX_W-1:0] clr_addr;
  logic              rd_stale;

  chip_word_t        chip_mem  [CHIP_SLOTS];
  stave_word_t       stave_mem [STAVE_SLOTS];
  chip_word_t        chip_rd;
  stave_word_t       stave_rd;

  cmd_t              b_cmd;
  logic              b_valid;

  logic              fwd_c_valid;
  logic [CIDX_W-1:0] fwd_c_addr;
  chip_word_t        fwd_c_word;
  logic              fwd_s_valid;
  logic [SIDX_W-1:0] fwd_s_addr;
  stave_word_t       fwd_s_word;

  logic [EPOCH_W-1:0]  epoch;
  logic                event_closed;
  logic [TOTAL_W-1:0]  totals      [3];
  logic [TOTAL_W-1:0]  totals_next [3];
  logic [EVT_W-1:0]    processed;
  logic [EVT_W-1:0]    above;
  logic [EVT_W-1:0]    processed_next;
  logic [EVT_W-1:0]    above_next;
  logic [THRESH_W-1:0] threshold;

  logic [CIDX_W-1:0]      b_cidx;
  logic [SIDX_W-1:0]      b_sidx;
  logic                   first_hit;
  logic                   need_wrap;
  logic                   b_go;
  logic                   load_b;
  logic                   hit_count;
  logic                   eoe_real;
  logic                   above_now;
  logic [EPOCH_W-1:0]     eff_epoch;
  logic                   c_fwd;
  logic                   s_fwd;
  chip_word_t             c_src;
  stave_word_t            s_src;
  logic                   c_live;
  logic                   s_live;
  logic [CHIP_CNT_W-1:0]  c_cnt;
  logic [CHIP_CNT_W-1:0]  c_new;
  logic [STAVE_CNT_W-1:0] s_cnt;
  logic [STAVE_CNT_W-1:0] s_new;

  // Pipeline control
  assign b_cidx    = b_cmd.c_idx[CIDX_W-1:0];
  assign b_sidx    = b_cmd.s_idx[SIDX_W-1:0];
  assign first_hit = (b_cmd.kind == CMD_HIT) && event_closed;
  // epoch rollover: wipe the histograms before the new event reuses tags
  assign need_wrap = b_valid && first_hit && (&epoch) && !rd_stale;
  assign b_go      = b_valid && (state == ST_RUN) && !need_wrap && !res_full;
  assign load_b    = !cmd_empty && (state == ST_RUN) && (!b_valid || b_go);
  assign cmd_pop   = load_b;
  assign res_push  = b_go;
  assign busy      = (state == ST_CLEAR);
  assign hit_count = b_go && (b_cmd.kind == CMD_HIT) && b_cmd.located;
  assign eoe_real  = (b_cmd.kind == CMD_EOE) && !event_closed;
  assign above_now = totals[0] > threshold;
  assign eff_epoch = first_hit ? epoch + 1'b1 : epoch;

  // Histogram words: forward the last write, then check the epoch tag
  assign c_fwd  = fwd_c_valid && (fwd_c_addr == b_cidx);
  assign s_fwd  = fwd_s_valid && (fwd_s_addr == b_sidx);
  assign c_src  = c_fwd ? fwd_c_word : chip_rd;
  assign s_src  = s_fwd ? fwd_s_word : stave_rd;
  assign c_live = (c_fwd || !rd_stale) && (c_src.epoch == eff_epoch);
  assign s_live = (s_fwd || !rd_stale) && (s_src.epoch == eff_epoch);
  assign c_cnt  = c_live ? c_src.cnt : '0;
  assign s_cnt  = s_live ? s_src.cnt : '0;
  assign c_new  = (&c_cnt) ? c_cnt : c_cnt + 1'b1;
  assign s_new  = (&s_cnt) ? s_cnt : s_cnt + 1'b1;

  // Layer totals, cleared by the first hit of an event
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      totals_next[i] = event_closed ? '0 : totals[i];
      if (b_cmd.located && (b_cmd.layer == 2'(i)) && !(&totals_next[i])) begin
        totals_next[i] = totals_next[i] + 1'b1;
      end
    end
  end

  // Event counters
  always_comb begin
    processed_next = processed;
    above_next     = above;
    if (eoe_real) begin
      if (!(&processed)) begin
        processed_next = processed + 1'b1;
      end
      if (above_now && !(&above)) begin
        above_next = above + 1'b1;
      end
    end
  end

  // Result assembly
  always_comb begin
    res                  = '0;
    res.events_processed = processed_next;
    res.events_above     = above_next;
    unique case (b_cmd.kind)
      CMD_HIT: begin
        res.hit_accepted = b_cmd.located;
        res.bad_address  = b_cmd.bad;
      end
      CMD_EOE: begin
        res.event_done = 1'b1;
        if (event_closed) begin
          res.event_empty = 1'b1;
        end else begin
          res.above_threshold = above_now;
          res.layer0_total    = totals[0];
          res.layer1_total    = totals[1];
          res.layer2_total    = totals[2];
        end
      end
      CMD_READ: begin
        res.bad_address = b_cmd.bad;
        if (b_cmd.located) begin
          res.count_value = b_cmd.rd_stave ? s_cnt : COUNT_W'(c_cnt);
        end
      end
      CMD_NOP: begin
      end
    endcase
  end

  // Sequencer: clearing sweep after reset and on epoch rollover
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_stale <= 1'b1;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == CIDX_W'(CHIP_SLOTS - 1)) begin
            state    <= ST_RUN;
            clr_addr <= '0;
            rd_stale <= 1'b1;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_RUN: begin
          if (need_wrap) begin
            state <= ST_CLEAR;
          end
          if (load_b) begin
            rd_stale <= 1'b0;
          end
        end
      endcase
    end
  end

  // Histogram memories
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      chip_mem[clr_addr] <= '0;
      if ({1'b0, clr_addr} < (CIDX_W + 1)'(STAVE_SLOTS)) begin
        stave_mem[clr_addr[SIDX_W-1:0]] <= '0;
      end
    end else if (hit_count) begin
      chip_mem[b_cidx]  <= '{epoch: eff_epoch, cnt: c_new};
      stave_mem[b_sidx] <= '{epoch: eff_epoch, cnt: s_new};
    end
    if (load_b) begin
      chip_rd  <= chip_mem[cmd.c_idx[CIDX_W-1:0]];
      stave_rd <= stave_mem[cmd.s_idx[SIDX_W-1:0]];
    end
  end

  // Last-write forwarding
  always_ff @(posedge clk) begin
    if (rst || (state == ST_CLEAR)) begin
      fwd_c_valid <= 1'b0;
      fwd_s_valid <= 1'b0;
    end else if (hit_count) begin
      fwd_c_valid <= 1'b1;
      fwd_s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_count) begin
      fwd_c_addr <= b_cidx;
      fwd_c_word <= '{epoch: eff_epoch, cnt: c_new};
      fwd_s_addr <= b_sidx;
      fwd_s_word <= '{epoch: eff_epoch, cnt: s_new};
    end
  end

  // Execute stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (load_b) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_cmd <= cmd;
    end
  end

  // Event state, counters and threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch        <= '0;
      event_closed <= 1'b1;
      processed    <= '0;
      above        <= '0;
      threshold    <= THRESH_RESET;
      for (int i = 0; i < 3; i++) begin
        totals[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        threshold <= cfg_data;
      end
      if (b_go) begin
        unique case (b_cmd.kind)
          CMD_HIT: begin
            epoch        <= eff_epoch;
            event_closed <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              totals[i] <= totals_next[i];
            end
          end
          CMD_EOE: begin
            processed    <= processed_next;
            above        <= above_next;
            event_closed <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // No result leaves while the histograms are being wiped
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !res_push)
    else $error("result pushed during clearing sweep");

  // Epoch moves only when the first hit of an event completes
  a_epoch_on_first_hit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (epoch != $past(epoch))) |-> $past(b_go && first_hit))
    else $error("epoch changed outside event start");

  // Above-threshold events are a subset of processed events
  a_above_le_processed: assert property (@(posedge clk) disable iff (rst)
    above <= processed)
    else $error("events above threshold exceed events processed");

endmodule

// ===== rtl/core/pixel_hit_occupancy_histogram.sv =====
// Channel   Handshake            Accepted when          Payload
// input     push / full          push && !full          item   (item_t)
// result    pop / empty          pop && !empty          result (result_t)
// config    cfg_valid/cfg_ready  cfg_valid && cfg_ready cfg_data (threshold)
//
// One request per cycle unless the wipe or a full result queue stalls; each request
// passes the request queue, execute stage and result queue. Chip and stave updates
// are read-modify-write with last-write forwarding, so repeated hits to one chip do
// not stall. After reset and when the 8-bit epoch wraps, full stays high while the
// STAVE_SLOTS*CHIPS_PER_STAVE chip slots (432 by default) of the histograms are wiped.
// full also rises when the 4-entry request queue fills behind a stalled result.
module pixel_hit_occupancy_histogram #(
  parameter int unsigned STAVES_LAYER0   = 12,
  parameter int unsigned STAVES_LAYER1   = 16,
  parameter int unsigned STAVES_LAYER2   = 20,
  parameter int unsigned CHIPS_PER_STAVE = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  phoh_pkg::item_t               item,
  output logic                          empty,
  input  logic                          pop,
  output phoh_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [phoh_pkg::THRESH_W-1:0] cfg_data
);

  import phoh_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(result_t);

  cmd_t             cmd_in;
  cmd_t             cmd_head;
  logic [CMD_W-1:0] cmd_head_bits;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;
  result_t          res;
  logic [RES_W-1:0] res_head_bits;
  logic             res_push;
  logic             res_full;
  logic             busy;

  // Threshold writes are always taken
  assign cfg_ready = 1'b1;
  assign full      = cmd_full || busy;
  assign cmd_head  = cmd_t'(cmd_head_bits);
  assign result    = result_t'(res_head_bits);

  phoh_front #(
    .STAVES_LAYER0  (STAVES_LAYER0),
    .STAVES_LAYER1  (STAVES_LAYER1),
    .STAVES_LAYER2  (STAVES_LAYER2),
    .CHIPS_PER_STAVE(CHIPS_PER_STAVE)
  ) u_front (
    .item(item),
    .cmd (cmd_in)
  );

  // Request queue between classification and execution
  phoh_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(4)
  ) u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push && !full),
    .wr_data(cmd_in),
    .full   (cmd_full),
    .rd_en  (cmd_pop),
    .rd_data(cmd_head_bits),
    .empty  (cmd_empty)
  );

  phoh_back #(
    .STAVES_LAYER0  (STAVES_LAYER0),
    .STAVES_LAYER1  (STAVES_LAYER1),
    .STAVES_LAYER2  (STAVES_LAYER2),
    .CHIPS_PER_STAVE(CHIPS_PER_STAVE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_head),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .busy     (busy)
  );

  // Result queue toward the consumer
  phoh_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_resq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop && !empty),
    .rd_data(res_head_bits),
    .empty  (empty)
  );

endmodule

// ===== bench/tb_pixel_hit_occupancy_histogram.sv =====
`timescale 1ns / 1ps

module tb_pixel_hit_occupancy_histogram;
  import phoh_pkg::*;

  // Geometry as built by default
  localparam int N_STAVE0   = 12;
  localparam int N_STAVE1   = 16;
  localparam int N_STAVE2   = 20;
  localparam int N_CHIPS    = 9;
  localparam int STAVE_SLOTS = N_STAVE0 + N_STAVE1 + N_STAVE2;
  localparam int CHIP_SLOTS  = STAVE_SLOTS * N_CHIPS;

  // Action code the block leaves alone
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [THRESH_W-1:0] THRESH_TOP = '1;

  logic                clk;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  item_t               item = '0;
  logic                empty;
  logic                pop = 1'b0;
  result_t             result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [THRESH_W-1:0] cfg_data = '0;

  pixel_hit_occupancy_histogram dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Histogram state mirrored on the bench side
  logic [THRESH_W-1:0]    thr_model;
  logic [CHIP_CNT_W-1:0]  chip_tally [CHIP_SLOTS];
  bit                     chip_live  [CHIP_SLOTS];
  logic [STAVE_CNT_W-1:0] stave_tally [STAVE_SLOTS];
  bit                     stave_live  [STAVE_SLOTS];
  logic [TOTAL_W-1:0]     layer_sum [3];
  logic [31:0]            event_entries;
  bit                     between_events;
  logic [EVT_W-1:0]       closed_events;
  logic [EVT_W-1:0]       hot_events;

  // Recently counted addresses; reads and repeat hits pick from these
  item_t hit_log [$];

  result_t owed_reports [$];
  int      failures;
  int      items_sent;
  bit      push_steady;
  bit      pop_steady;
  int      pop_hold_cycles;

  function automatic int staves_of(input int layer);
    case (layer)
      0:       return N_STAVE0;
      1:       return N_STAVE1;
      default: return N_STAVE2;
    endcase
  endfunction

  function automatic int stave_base(input int layer);
    case (layer)
      0:       return 0;
      1:       return N_STAVE0;
      default: return N_STAVE0 + N_STAVE1;
    endcase
  endfunction

  // Map layer/stave/chip to slot numbers; 0 when outside the geometry
  function automatic bit find_slot(input logic [1:0] layer, input logic [4:0] stave,
                                   input logic [3:0] chip, input bit need_chip,
                                   output int s_idx, output int c_idx);
    s_idx = 0;
    c_idx = 0;
    if (layer == LAYER_ENTRY_ONLY) return 1'b0;
    if (int'(stave) >= staves_of(int'(layer))) return 1'b0;
    if (need_chip && int'(chip) >= N_CHIPS) return 1'b0;
    s_idx = stave_base(int'(layer)) + int'(stave);
    c_idx = s_idx * N_CHIPS + ((int'(chip) < N_CHIPS) ? int'(chip) : 0);
    return 1'b1;
  endfunction

  task automatic clear_histogram_model();
    thr_model      = THRESH_RESET;
    event_entries  = '0;
    between_events = 1'b1;
    closed_events  = '0;
    hot_events     = '0;
    foreach (chip_live[i]) begin
      chip_live[i]  = 1'b0;
      chip_tally[i] = '0;
    end
    foreach (stave_live[i]) begin
      stave_live[i]  = 1'b0;
      stave_tally[i] = '0;
    end
    foreach (layer_sum[i]) layer_sum[i] = '0;
  endtask

  // Apply one request to the mirrored histograms, return the report it produces
  function automatic result_t histogram_apply(input item_t it);
    result_t r;
    int      s_idx;
    int      c_idx;
    bit      above;
    r = '0;
    case (it.action)
      ACT_HIT: begin
        // first hit of an event wipes the previous event's histograms
        if (between_events) begin
          foreach (chip_live[i]) chip_live[i] = 1'b0;
          foreach (stave_live[i]) stave_live[i] = 1'b0;
          foreach (layer_sum[i]) layer_sum[i] = '0;
          event_entries  = '0;
          between_events = 1'b0;
        end
        if (!(&event_entries)) event_entries = event_entries + 1'b1;
        if (it.layer != LAYER_ENTRY_ONLY) begin
          if (find_slot(it.layer, it.stave, it.chip, 1'b1, s_idx, c_idx)) begin
            if (!chip_live[c_idx]) chip_tally[c_idx] = CHIP_CNT_W'(1);
            else if (!(&chip_tally[c_idx])) chip_tally[c_idx] = chip_tally[c_idx] + 1'b1;
            if (!stave_live[s_idx]) stave_tally[s_idx] = STAVE_CNT_W'(1);
            else if (!(&stave_tally[s_idx])) stave_tally[s_idx] = stave_tally[s_idx] + 1'b1;
            if (!(&layer_sum[it.layer])) layer_sum[it.layer] = layer_sum[it.layer] + 1'b1;
            chip_live[c_idx]   = 1'b1;
            stave_live[s_idx]  = 1'b1;
            r.hit_accepted     = 1'b1;
            hit_log.insert(hit_log.size(), it);
            if (hit_log.size() > 64) void'(hit_log.pop_front());
          end else begin
            r.bad_address = 1'b1;
          end
        end
      end
      ACT_EOE: begin
        r.event_done = 1'b1;
        if (between_events || event_entries == 0) begin
          r.event_empty = 1'b1;
        end else begin
          above = layer_sum[0] > thr_model;
          if (!(&closed_events)) closed_events = closed_events + 1'b1;
          if (above && !(&hot_events)) hot_events = hot_events + 1'b1;
          between_events    = 1'b1;
          r.above_threshold = above;
          r.layer0_total    = layer_sum[0];
          r.layer1_total    = layer_sum[1];
          r.layer2_total    = layer_sum[2];
        end
      end
      ACT_READ: begin
        if (find_slot(it.layer, it.stave, it.chip, !it.read_stave_total, s_idx, c_idx)) begin
          if (it.read_stave_total)
            r.count_value = stave_live[s_idx] ? stave_tally[s_idx] : '0;
          else
            r.count_value = chip_live[c_idx] ? COUNT_W'(chip_tally[c_idx]) : '0;
        end else begin
          r.bad_address = 1'b1;
        end
      end
      default: ;
    endcase
    r.events_processed = closed_events;
    r.events_above     = hot_events;
    return r;
  endfunction

  function automatic item_t mk_item(input logic [1:0] act, input logic [1:0] layer,
                                    input logic [4:0] stave, input logic [3:0] chip,
                                    input logic rd);
    item_t it;
    it.action           = act;
    it.layer            = layer;
    it.stave            = stave;
    it.chip             = chip;
    it.read_stave_total = rd;
    return it;
  endfunction

  // Mostly short idle spans, now and then a long one
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t rand_good_hit();
    item_t it;
    int    layer;
    if (hit_log.size() != 0 && $urandom_range(0, 3) == 0) begin
      // revisit a chip already hit
      it = hit_log[$urandom_range(0, hit_log.size() - 1)];
      it.action = ACT_HIT;
      it.read_stave_total = 1'($urandom_range(0, 1));
      return it;
    end
    layer = $urandom_range(0, 2);
    return mk_item(ACT_HIT, 2'(layer), 5'($urandom_range(0, staves_of(layer) - 1)),
                   4'($urandom_range(0, N_CHIPS - 1)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic item_t rand_bad_hit();
    int layer;
    layer = $urandom_range(0, 2);
    if ($urandom_range(0, 1))
      return mk_item(ACT_HIT, 2'(layer), 5'($urandom_range(staves_of(layer), 31)),
                     4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    return mk_item(ACT_HIT, 2'(layer), 5'($urandom_range(0, staves_of(layer) - 1)),
                   4'($urandom_range(N_CHIPS, 15)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic item_t rand_read();
    item_t it;
    int    layer;
    if (hit_log.size() == 0 || $urandom_range(0, 4) == 0) begin
      // outside the geometry
      layer = $urandom_range(0, 2);
      case ($urandom_range(0, 2))
        0: return mk_item(ACT_READ, LAYER_ENTRY_ONLY, 5'($urandom_range(0, 31)),
                          4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        1: return mk_item(ACT_READ, 2'(layer), 5'($urandom_range(staves_of(layer), 31)),
                          4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        default: return mk_item(ACT_READ, 2'(layer),
                                5'($urandom_range(0, staves_of(layer) - 1)),
                                4'($urandom_range(N_CHIPS, 15)), 1'b0);
      endcase
    end
    it = hit_log[$urandom_range(0, hit_log.size() - 1)];
    it.action = ACT_READ;
    it.read_stave_total = 1'($urandom_range(0, 1));
    if (it.read_stave_total) it.chip = 4'($urandom_range(0, 15));
    return it;
  endfunction

  function automatic item_t rand_noise();
    return mk_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)));
  endfunction

  // Push one request, predict its report on acceptance, then maybe idle
  task automatic send_item(input item_t it);
    int gap;
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    owed_reports.insert(owed_reports.size(), histogram_apply(it));
    items_sent++;
    if (!push_steady) begin
      gap = idle_span();
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop pushing and let all owed reports come back
  task automatic drain(input int limit);
    push <= 1'b0;
    while (owed_reports.size() != 0 && limit > 0) begin
      @(posedge clk);
      limit--;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THRESH_W-1:0] value);
    drain(100000);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    thr_model = value;
  endtask

  task automatic send_eoe();
    send_item(mk_item(ACT_EOE, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                      4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
  endtask

  // One event of hits on a single layer, then close it
  task automatic layer_event(input int layer, input int hits);
    repeat (hits)
      send_item(mk_item(ACT_HIT, 2'(layer), 5'($urandom_range(0, staves_of(layer) - 1)),
                        4'($urandom_range(0, N_CHIPS - 1)), 1'b0));
    send_eoe();
  endtask

  // Mixed event: good, bad and entry-only hits, reads, unused actions
  task automatic random_event(input int max_len);
    int n;
    int r;
    n = $urandom_range(0, max_len);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 62) send_item(rand_good_hit());
      else if (r < 72) send_item(rand_bad_hit());
      else if (r < 80)
        send_item(mk_item(ACT_HIT, LAYER_ENTRY_ONLY, 5'($urandom_range(0, 31)),
                          4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      else if (r < 97) send_item(rand_read());
      else send_item(mk_item(ACT_UNUSED, 2'($urandom_range(0, 3)),
                             5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                             1'($urandom_range(0, 1))));
    end
    send_eoe();
    if ($urandom_range(0, 9) == 0) send_eoe();
  endtask

  // Geometry edges, bad addresses, empty and entry-only events
  task automatic test_directed();
    push_steady = 1'b1;
    send_item(mk_item(ACT_READ, LAYER_ENTRY_ONLY, 5'd0, 4'd0, 1'b0));
    send_item(mk_item(ACT_EOE, 2'd0, 5'd0, 4'd0, 1'b0));
    send_item(mk_item(ACT_UNUSED, LAYER_ENTRY_ONLY, 5'd31, 4'd15, 1'b1));
    send_item(mk_item(ACT_HIT, 2'd0, 5'd0, 4'd0, 1'b0));
    send_item(mk_item(ACT_HIT, 2'd0, 5'd0, 4'd0, 1'b1));
    send_item(mk_item(ACT_HIT, 2'd0, 5'd11, 4'd8, 1'b0));
    send_item(mk_item(ACT_HIT, 2'd1, 5'd15, 4'd0, 1'b0));
    send_item(mk_item(ACT_HIT, 2'd2, 5'd19, 4'd8, 1'b0));
    send_item(mk_item(ACT_HIT, 2'd2, 5'd31, 4'd15, 1'b0));
    send_item(mk_item(ACT_HIT, 2'd0, 5'd12, 4'd0, 1'b0));
    send_item(mk_item(ACT_HIT, 2'd1, 5'd3, 4'd9, 1'b0));
    send_item(mk_item(ACT_HIT, LAYER_ENTRY_ONLY, 5'd7, 4'd2, 1'b0));
    push_steady = 1'b0;
    send_item(mk_item(ACT_READ, 2'd0, 5'd0, 4'd0, 1'b0));
    send_item(mk_item(ACT_READ, 2'd0, 5'd0, 4'd15, 1'b1));
    send_item(mk_item(ACT_READ, 2'd0, 5'd0, 4'd9, 1'b0));
    send_item(mk_item(ACT_READ, 2'd1, 5'd16, 4'd0, 1'b1));
    send_item(mk_item(ACT_READ, 2'd2, 5'd19, 4'd3, 1'b1));
    send_item(mk_item(ACT_EOE, 2'd0, 5'd0, 4'd0, 1'b0));
    send_item(mk_item(ACT_EOE, LAYER_ENTRY_ONLY, 5'd31, 4'd15, 1'b1));
    // closed event stays readable until the next hit wipes it
    send_item(mk_item(ACT_READ, 2'd0, 5'd11, 4'd8, 1'b0));
    send_item(mk_item(ACT_HIT, LAYER_ENTRY_ONLY, 5'd0, 4'd0, 1'b0));
    send_item(mk_item(ACT_READ, 2'd0, 5'd11, 4'd8, 1'b0));
    send_item(mk_item(ACT_EOE, 2'd0, 5'd0, 4'd0, 1'b0));
    send_item(mk_item(ACT_HIT, 2'd1, 5'd20, 4'd0, 1'b0));
    send_item(mk_item(ACT_EOE, 2'd0, 5'd0, 4'd0, 1'b0));
  endtask

  // Events well under the reset threshold; repeats on one chip and stave
  task automatic test_reset_threshold();
    push_steady = 1'b1;
    pop_steady  = 1'b1;
    layer_event(0, 10);
    repeat (12) send_item(mk_item(ACT_HIT, 2'd0, 5'd5, 4'd4, 1'b0));
    send_item(mk_item(ACT_HIT, 2'd0, 5'd5, 4'd7, 1'b0));
    send_eoe();
    send_item(mk_item(ACT_READ, 2'd0, 5'd5, 4'd4, 1'b0));
    send_item(mk_item(ACT_READ, 2'd0, 5'd5, 4'd12, 1'b1));
    push_steady = 1'b0;
    pop_steady  = 1'b0;
  endtask

  // Threshold extremes and a small boundary
  task automatic test_threshold_settings();
    write_threshold('0);
    layer_event(0, 1);
    layer_event(1, 2);
    write_threshold(THRESH_TOP);
    layer_event(0, 3);
    write_threshold(26'd3);
    layer_event(0, 3);
    layer_event(0, 4);
    layer_event(2, 5);
  endtask

  // Result side holds off long enough that the request queue fills and full rises
  task automatic test_result_stall();
    drain(100000);
    pop_hold_cycles = 80;
    while (pop_hold_cycles != 0) @(posedge clk);
    push_steady = 1'b1;
    repeat (16) send_item(rand_good_hit());
    send_eoe();
    random_event(12);
    push_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int ev;
    ev = 0;
    while (items_sent < 400) begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_item(rand_noise());
      else random_event(10);
      ev++;
      if (ev % 12 == 0) write_threshold(THRESH_W'($urandom_range(0, 8)));
      // stretches where neither side idles
      if (ev % 20 == 10) begin
        push_steady = 1'b1;
        pop_steady  = 1'b1;
      end
      if (ev % 20 == 15) begin
        push_steady = 1'b0;
        pop_steady  = 1'b0;
      end
    end
    push_steady = 1'b0;
    pop_steady  = 1'b0;
  endtask

  // Result side: random pop bursts and gaps, or a requested long hold-off
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (pop_hold_cycles > 0) begin
        n = pop_hold_cycles;
        pop_hold_cycles = 0;
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (pop_steady) begin
        pop <= 1'b1;
        @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        n = idle_span();
        if (n > 0) begin
          pop <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Compare each popped report with the oldest prediction
  always @(posedge clk) begin : check_reports
    result_t want;
    if (!rst && pop && !empty) begin
      if (owed_reports.size() == 0) begin
        failures++;
        if (failures <= 10) $display("report popped with none owed");
      end else begin
        want = owed_reports.pop_front();
        check_field("hit_accepted", 64'(want.hit_accepted), 64'(result.hit_accepted));
        check_field("bad_address", 64'(want.bad_address), 64'(result.bad_address));
        check_field("event_done", 64'(want.event_done), 64'(result.event_done));
        check_field("event_empty", 64'(want.event_empty), 64'(result.event_empty));
        check_field("above_threshold", 64'(want.above_threshold),
                    64'(result.above_threshold));
        check_field("layer0_total", 64'(want.layer0_total), 64'(result.layer0_total));
        check_field("layer1_total", 64'(want.layer1_total), 64'(result.layer1_total));
        check_field("layer2_total", 64'(want.layer2_total), 64'(result.layer2_total));
        check_field("events_processed", 64'(want.events_processed),
                    64'(result.events_processed));
        check_field("events_above", 64'(want.events_above), 64'(result.events_above));
        check_field("count_value", 64'(want.count_value), 64'(result.count_value));
      end
    end
  end

  initial begin
    failures        = 0;
    items_sent      = 0;
    push_steady     = 1'b0;
    pop_steady      = 1'b0;
    pop_hold_cycles = 0;
    clear_histogram_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_reset_threshold();
    test_threshold_settings();
    test_result_stall();
    test_random_traffic();

    drain(50000);
    if (owed_reports.size() != 0) begin
      failures += owed_reports.size();
      $display("%0d reports never arrived", owed_reports.size());
    end
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
